FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: design/vmbms_pkg.sv
// ----------------------------------------------------------------------------
// vmbms_pkg
// Types and constants for the video mode best match selector.
// ----------------------------------------------------------------------------
package vmbms_pkg;

	// Descriptor constants
	localparam logic [15:0] MODE_END       = 16'hFFFF;
	localparam logic [15:0] ATTR_SUPPORTED = 16'h0001;
	localparam logic [15:0] ATTR_LFB       = 16'h0090;
	localparam logic [7:0]  MODEL_DIRECT   = 8'd6;

	// Register reset values
	localparam logic [15:0] WANTED_WIDTH_RST  = 16'd1024;
	localparam logic [15:0] WANTED_HEIGHT_RST = 16'd768;
	localparam logic [7:0]  WANTED_DEPTH_RST  = 8'd32;
	localparam logic [31:0] WANTED_PIXELS_RST = 32'd786432;

	// Tracking state reset values
	localparam logic [31:0] PIX_DIST_RST = 32'hFFFF_FFFF;
	localparam logic [7:0]  DEP_DIST_RST = 8'hFF;

	// Configuration port widths
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WANTED_WIDTH  = 2'd0,
		REG_WANTED_HEIGHT = 2'd1,
		REG_WANTED_DEPTH  = 2'd2
	} vmbms_reg_t;

	// Input request payload
	typedef struct packed {
		logic [15:0] mode_number;
		logic        info_valid;
		logic [15:0] mode_attributes;
		logic [7:0]  memory_model;
		logic [15:0] res_x;
		logic [15:0] res_y;
		logic [7:0]  depth_bits;
	} vmbms_in_t;

	// Result payload
	typedef struct packed {
		logic        found;
		logic [15:0] best_mode;
		logic        exact;
	} vmbms_out_t;

	// Targets derived from the configuration registers
	typedef struct packed {
		logic [31:0] wanted_pixels;
		logic [7:0]  wanted_depth;
	} vmbms_cfg_t;

	// Qualified descriptor handed from the prepare stage to the selector
	typedef struct packed {
		logic        valid;
		logic        term;
		logic        cand;
		logic [15:0] mode;
		logic [31:0] pixels;
		logic [7:0]  dep_dist;
	} vmbms_cand_t;

endpackage

FILE: design/vmbms_cfg.sv
// ----------------------------------------------------------------------------
// vmbms_cfg
// Configuration registers and the registered wanted pixel count.
// ----------------------------------------------------------------------------
module vmbms_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vmbms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vmbms_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output vmbms_pkg::vmbms_cfg_t               cfg
);

	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [7:0]  depth_q;
	logic [31:0] pixels_q;

	// Register writes; the product is formed from the value being written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= vmbms_pkg::WANTED_WIDTH_RST;
			height_q <= vmbms_pkg::WANTED_HEIGHT_RST;
			depth_q  <= vmbms_pkg::WANTED_DEPTH_RST;
			pixels_q <= vmbms_pkg::WANTED_PIXELS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vmbms_pkg::REG_WANTED_WIDTH: begin
					width_q  <= cfg_wdata;
					pixels_q <= 32'(cfg_wdata) * 32'(height_q);
				end
				vmbms_pkg::REG_WANTED_HEIGHT: begin
					height_q <= cfg_wdata;
					pixels_q <= 32'(width_q) * 32'(cfg_wdata);
				end
				vmbms_pkg::REG_WANTED_DEPTH: begin
					depth_q <= cfg_wdata[7:0];
				end
				default: begin
					// unused index: write dropped
				end
			endcase
		end
	end

	assign cfg.wanted_pixels = pixels_q;
	assign cfg.wanted_depth  = depth_q;

endmodule

FILE: design/vmbms_prep.sv
// ----------------------------------------------------------------------------
// vmbms_prep
// Input register, descriptor qualification, pixel count and depth distance.
// ----------------------------------------------------------------------------
module vmbms_prep (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   in_valid,
	input  vmbms_pkg::vmbms_in_t   in_data,
	input  vmbms_pkg::vmbms_cfg_t  cfg,
	output vmbms_pkg::vmbms_cand_t cand_s2
);

	logic                 valid_s1;
	vmbms_pkg::vmbms_in_t item_s1;
	logic                 valid_s2;
	logic                 term_s2;
	logic                 cand_ok_s2;
	logic [15:0]          mode_s2;
	logic [31:0]          pixels_s2;
	logic [7:0]           dep_dist_s2;

	logic       term;
	logic       cand_ok;
	logic [7:0] dep_dist;

	// Stage 1: capture the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Qualification and depth distance
	always_comb begin
		term    = (item_s1.mode_number == vmbms_pkg::MODE_END);
		cand_ok = item_s1.info_valid
			&& ((item_s1.mode_attributes & vmbms_pkg::ATTR_SUPPORTED)
				== vmbms_pkg::ATTR_SUPPORTED)
			&& ((item_s1.mode_attributes & vmbms_pkg::ATTR_LFB) == vmbms_pkg::ATTR_LFB)
			&& (item_s1.memory_model == vmbms_pkg::MODEL_DIRECT);
		if (item_s1.depth_bits > cfg.wanted_depth) begin
			dep_dist = item_s1.depth_bits - cfg.wanted_depth;
		end else begin
			dep_dist = cfg.wanted_depth - item_s1.depth_bits;
		end
	end

	// Stage 2: registered product and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			term_s2     <= term;
			cand_ok_s2  <= cand_ok;
			mode_s2     <= item_s1.mode_number;
			pixels_s2   <= 32'(item_s1.res_x) * 32'(item_s1.res_y);
			dep_dist_s2 <= dep_dist;
		end
	end

	assign cand_s2.valid    = valid_s2;
	assign cand_s2.term     = term_s2;
	assign cand_s2.cand     = cand_ok_s2;
	assign cand_s2.mode     = mode_s2;
	assign cand_s2.pixels   = pixels_s2;
	assign cand_s2.dep_dist = dep_dist_s2;

endmodule

FILE: design/vmbms_select.sv
// ----------------------------------------------------------------------------
// vmbms_select
// Best-match tracking state and the result register.
// ----------------------------------------------------------------------------
module vmbms_select (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  vmbms_pkg::vmbms_cand_t cand_s2,
	input  vmbms_pkg::vmbms_cfg_t  cfg,
	output logic                   out_valid,
	output vmbms_pkg::vmbms_out_t  out_data
);

	logic [15:0] best_mode_q;
	logic [31:0] best_pix_q;
	logic [7:0]  best_dep_q;
	logic        skip_q;
	logic        out_valid_q;
	vmbms_pkg::vmbms_out_t out_q;

	logic [31:0] pix_dist;
	logic        better;
	logic        perfect;

	// Pixel distance and comparison against the current best
	always_comb begin
		if (cand_s2.pixels > cfg.wanted_pixels) begin
			pix_dist = cand_s2.pixels - cfg.wanted_pixels;
		end else begin
			pix_dist = cfg.wanted_pixels - cand_s2.pixels;
		end
		better  = (pix_dist < best_pix_q)
			|| ((pix_dist == best_pix_q) && (cand_s2.dep_dist < best_dep_q));
		perfect = (pix_dist == 32'd0) && (cand_s2.dep_dist == 8'd0);
	end

	// Tracking state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_mode_q <= 16'd0;
			best_pix_q  <= vmbms_pkg::PIX_DIST_RST;
			best_dep_q  <= vmbms_pkg::DEP_DIST_RST;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b0;
			if (cand_s2.valid) begin
				if (cand_s2.term) begin
					// end of list: report unless already reported, then clear
					out_valid_q <= !skip_q;
					best_mode_q <= 16'd0;
					best_pix_q  <= vmbms_pkg::PIX_DIST_RST;
					best_dep_q  <= vmbms_pkg::DEP_DIST_RST;
					skip_q      <= 1'b0;
				end else if (!skip_q && cand_s2.cand && better) begin
					best_mode_q <= cand_s2.mode;
					best_pix_q  <= pix_dist;
					best_dep_q  <= cand_s2.dep_dist;
					if (perfect) begin
						skip_q      <= 1'b1;
						out_valid_q <= 1'b1;
					end
				end
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance && cand_s2.valid) begin
			if (cand_s2.term) begin
				out_q.found     <= (best_mode_q != 16'd0);
				out_q.best_mode <= best_mode_q;
				out_q.exact     <= 1'b0;
			end else begin
				out_q.found     <= (cand_s2.mode != 16'd0);
				out_q.best_mode <= cand_s2.mode;
				out_q.exact     <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: design/video_mode_best_match_selector_unit.sv
// ----------------------------------------------------------------------------
// video_mode_best_match_selector_unit
// Picks the display mode closest to a wanted width, height and depth.
// ----------------------------------------------------------------------------
// Usage:
//   Mode descriptors arrive one request at a time on the input channel
//   (in_valid / in_stall / in_data); mode 0xFFFF ends the list. The output
//   channel (out_valid / out_stall / out_data) carries at most one result per
//   descriptor: on a perfect match, and on the end marker unless a perfect
//   match was already reported for that list.
//   The request is captured in the input register, the product and flags
//   are registered, and the compare and update reach the result register,
//   which drives out_valid. One descriptor is taken every cycle while no
//   result is held back by out_stall; the best-match state is updated as
//   each descriptor passes, so lists of any length stream without gaps.
//   The wanted width, height and depth are written through cfg_we,
//   cfg_index and cfg_wdata while no list is in flight; the wanted pixel
//   count is registered at the write.
//   Reset restores the register defaults (1024 x 768, 32 bpp), clears the
//   best-match state and empties the pipeline.
//   While a result waits with out_stall high the whole pipeline holds and
//   in_stall is raised; otherwise new requests are taken as results leave.
// ----------------------------------------------------------------------------
module video_mode_best_match_selector_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  vmbms_pkg::vmbms_in_t             in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output vmbms_pkg::vmbms_out_t            out_data,
	input  logic                             cfg_we,
	input  logic [vmbms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vmbms_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	vmbms_pkg::vmbms_cfg_t  cfg;
	vmbms_pkg::vmbms_cand_t cand_s2;
	logic                   advance;

	// Pipeline moves unless a waiting result is held back
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	vmbms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	vmbms_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_valid(in_valid),
		.in_data (in_data),
		.cfg     (cfg),
		.cand_s2 (cand_s2)
	);

	vmbms_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cand_s2  (cand_s2),
		.cfg      (cfg),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

FILE: design/vmbms_checker.sv
// ----------------------------------------------------------------------------
// vmbms_checker
// Port-level checks on the selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vmbms_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input vmbms_pkg::vmbms_out_t out_data
);

	// found flag agrees with the reported mode
	`ASSERT_IMPLIES(a_found_matches_mode, clk, arst_n, out_valid, out_data.found == (out_data.best_mode != 16'd0))

	// input held back only while a result is held back
	`ASSERT_IMPLIES(a_stall_only_on_backpressure, clk, arst_n, in_stall, out_valid && out_stall)

	// a held result stays offered
	`ASSERT_NEXT(a_out_valid_holds, clk, arst_n, out_valid && out_stall, out_valid)

	// a held result keeps its payload
	`ASSERT_NEXT(a_out_data_holds, clk, arst_n, out_valid && out_stall, $stable(out_data))

endmodule

bind video_mode_best_match_selector_unit vmbms_checker u_vmbms_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for video_mode_best_match_selector_unit.
// Streams mode descriptor lists through the valid/stall channels and
// predicts each best-match result with a behavioural copy of the selector.
// Register settings, idle/stall mixes, a long output hold and a mid-list
// drain are all exercised. Every accepted result is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [vmbms_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 200;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	vmbms_pkg::vmbms_in_t             in_data;
	logic                             out_valid;
	logic                             out_stall;
	vmbms_pkg::vmbms_out_t            out_data;
	logic                             cfg_we;
	logic [vmbms_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [vmbms_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// Behavioural copy of the wanted targets and the best-match state
	logic [15:0] want_w;
	logic [15:0] want_h;
	logic [7:0]  want_d;
	logic [15:0] best_mode;
	logic [31:0] best_pix;
	logic [7:0]  best_dep;
	bit          skip_rest;

	vmbms_pkg::vmbms_out_t expected_results[$];

	int n_errors;
	int n_sent;
	int n_lists;
	int n_results;
	int n_exact;
	int idle_pct;
	int stall_pct;
	int hold_left;
	int quiet_cycles;

	video_mode_best_match_selector_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Clears the tracking state, as the terminator and reset do
	function automatic void clear_best();
		best_mode = '0;
		best_pix  = vmbms_pkg::PIX_DIST_RST;
		best_dep  = vmbms_pkg::DEP_DIST_RST;
		skip_rest = 1'b0;
	endfunction

	// Advances the best-match state by one descriptor; returns 1 with a result
	function automatic bit pick_best_mode(input vmbms_pkg::vmbms_in_t d,
			output vmbms_pkg::vmbms_out_t r);
		logic [31:0] have_pix;
		logic [31:0] want_pix;
		logic [31:0] pix_dist;
		logic [7:0]  dep_dist;
		bit          emit;
		r = '0;
		if (d.mode_number == vmbms_pkg::MODE_END) begin
			emit = !skip_rest;
			r.found = (best_mode != '0);
			r.best_mode = best_mode;
			r.exact = 1'b0;
			clear_best();
			return emit;
		end
		if (skip_rest || !d.info_valid) return 1'b0;
		if ((d.mode_attributes & vmbms_pkg::ATTR_SUPPORTED) != vmbms_pkg::ATTR_SUPPORTED)
			return 1'b0;
		if ((d.mode_attributes & vmbms_pkg::ATTR_LFB) != vmbms_pkg::ATTR_LFB) return 1'b0;
		if (d.memory_model != vmbms_pkg::MODEL_DIRECT) return 1'b0;
		have_pix = 32'(d.res_x) * 32'(d.res_y);
		want_pix = 32'(want_w) * 32'(want_h);
		pix_dist = (have_pix > want_pix) ? have_pix - want_pix : want_pix - have_pix;
		dep_dist = (d.depth_bits > want_d) ? d.depth_bits - want_d : want_d - d.depth_bits;
		if (pix_dist < best_pix || (pix_dist == best_pix && dep_dist < best_dep)) begin
			best_mode = d.mode_number;
			best_pix  = pix_dist;
			best_dep  = dep_dist;
			if (pix_dist == '0 && dep_dist == '0) begin
				skip_rest = 1'b1;
				r.found = (best_mode != '0);
				r.best_mode = best_mode;
				r.exact = 1'b1;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic vmbms_pkg::vmbms_in_t mode_desc(input logic [15:0] num,
			input logic ok, input logic [15:0] attr, input logic [7:0] model,
			input logic [15:0] x, input logic [15:0] y, input logic [7:0] dep);
		vmbms_pkg::vmbms_in_t d;
		d.mode_number = num;
		d.info_valid = ok;
		d.mode_attributes = attr;
		d.memory_model = model;
		d.res_x = x;
		d.res_y = y;
		d.depth_bits = dep;
		return d;
	endfunction

	// End-of-list marker with junk in the other fields
	function automatic vmbms_pkg::vmbms_in_t list_end();
		return mode_desc(vmbms_pkg::MODE_END, 1'($urandom_range(1)),
			16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)),
			16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
			8'($urandom_range(8'hFF)));
	endfunction

	// Mostly qualifying descriptors near the target; some broken, some noise
	function automatic vmbms_pkg::vmbms_in_t random_mode();
		vmbms_pkg::vmbms_in_t d;
		int pick;
		d = mode_desc(16'($urandom_range(16'hFFFE)), 1'($urandom_range(1)),
			16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)),
			16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
			8'($urandom_range(8'hFF)));
		if ($urandom_range(19) == 0) d.mode_number = '0;
		pick = $urandom_range(99);
		if (pick < 90) begin
			d.info_valid = 1'b1;
			d.mode_attributes = d.mode_attributes | vmbms_pkg::ATTR_SUPPORTED
				| vmbms_pkg::ATTR_LFB;
			d.memory_model = vmbms_pkg::MODEL_DIRECT;
		end
		if (pick >= 85 && pick < 90) begin
			case ($urandom_range(3))
				0: d.info_valid = 1'b0;
				1: d.mode_attributes = d.mode_attributes & ~vmbms_pkg::ATTR_SUPPORTED;
				// drop bit 4 or bit 7
				2: d.mode_attributes = d.mode_attributes
					& ~(16'h0010 << (3 * $urandom_range(1)));
				default: d.memory_model = d.memory_model ^ (8'd1 << $urandom_range(7));
			endcase
		end
		// Resolution: exact, swapped, near or anywhere
		pick = $urandom_range(9);
		if (pick < 3) begin
			d.res_x = want_w;
			d.res_y = want_h;
		end else if (pick == 3) begin
			d.res_x = want_h;
			d.res_y = want_w;
		end else if (pick < 7) begin
			d.res_x = 16'(want_w + $urandom_range(2) - 1);
			d.res_y = 16'(want_h + $urandom_range(2) - 1);
		end
		pick = $urandom_range(3);
		if (pick < 2) d.depth_bits = want_d;
		else if (pick == 2) d.depth_bits = 8'(want_d + $urandom_range(4) - 2);
		return d;
	endfunction

	// Offers one request, with random idle cycles first, and records the prediction
	task automatic send_request(input vmbms_pkg::vmbms_in_t d);
		vmbms_pkg::vmbms_out_t r;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (in_stall);
		n_sent++;
		if (d.mode_number == vmbms_pkg::MODE_END) n_lists++;
		if (pick_best_mode(d, r)) expected_results.push_back(r);
	endtask

	task automatic send_list(input int len);
		for (int i = 0; i < len; i++) send_request(random_mode());
		send_request(list_end());
	endtask

	// Stops offering and waits for every outstanding result
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [vmbms_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vmbms_pkg::REG_WANTED_WIDTH:  want_w = value;
			vmbms_pkg::REG_WANTED_HEIGHT: want_h = value;
			vmbms_pkg::REG_WANTED_DEPTH:  want_d = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_targets(input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] dep);
		write_reg(vmbms_pkg::REG_WANTED_WIDTH, w);
		write_reg(vmbms_pkg::REG_WANTED_HEIGHT, h);
		// upper byte is junk; only the low byte should be kept
		write_reg(vmbms_pkg::REG_WANTED_DEPTH, {8'($urandom_range(8'hFF)), dep});
	endtask

	// Directed: qualification rules, ties, field extremes, perfect matches
	task automatic test_directed_filters();
		send_request(mode_desc(vmbms_pkg::MODE_END, 1'b0, '0, '0, '0, '0, '0));
		send_request(mode_desc(16'h0101, 1'b1, 16'h0091, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd24));
		send_request(mode_desc(16'h0102, 1'b0, 16'hFFFF, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd32));
		send_request(mode_desc(16'h0103, 1'b1, 16'h0090, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd32));
		send_request(mode_desc(16'h0104, 1'b1, 16'h0081, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd32));
		send_request(mode_desc(16'h0105, 1'b1, 16'h0011, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd32));
		send_request(mode_desc(16'h0106, 1'b1, 16'h0091, 8'h00, 16'd1024, 16'd768, 8'd32));
		send_request(mode_desc(16'h0107, 1'b1, 16'hFFFF, 8'hFF, 16'd1024, 16'd768, 8'd32));
		// same pixel count, closer depth wins; equal depth distance does not
		send_request(mode_desc(16'h0108, 1'b1, 16'h0091, vmbms_pkg::MODEL_DIRECT,
			16'd768, 16'd1024, 8'd28));
		send_request(mode_desc(16'h0109, 1'b1, 16'h0091, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd36));
		send_request(mode_desc(vmbms_pkg::MODE_END, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF,
			16'hFFFF, 8'hFF));
		// largest and smallest resolutions, best ends on mode zero
		send_request(mode_desc(16'hFFFE, 1'b1, 16'hFFFF, vmbms_pkg::MODEL_DIRECT,
			16'hFFFF, 16'hFFFF, 8'hFF));
		send_request(mode_desc(16'h0000, 1'b1, 16'h0091, vmbms_pkg::MODEL_DIRECT,
			'0, '0, '0));
		send_request(mode_desc(vmbms_pkg::MODE_END, 1'b0, '0, '0, '0, '0, '0));
		// perfect match, then ignored items and a silent terminator
		send_request(mode_desc(16'h0111, 1'b1, 16'h0091, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd32));
		send_request(mode_desc(16'h0112, 1'b1, 16'h0091, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd32));
		send_request(mode_desc(vmbms_pkg::MODE_END, 1'b0, '0, '0, '0, '0, '0));
		send_request(mode_desc(16'h0000, 1'b1, 16'hFFFF, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd32));
		send_request(mode_desc(vmbms_pkg::MODE_END, 1'b0, 16'hFFFF, 8'hFF, 16'hFFFF,
			16'hFFFF, 8'hFF));
		settle();
	endtask

	// A write to the spare index must leave the targets alone
	task automatic test_unused_register();
		write_reg(REG_UNUSED, 16'h0000);
		send_request(mode_desc(16'h0120, 1'b1, 16'h0091, vmbms_pkg::MODEL_DIRECT,
			16'd1024, 16'd768, 8'd32));
		send_request(list_end());
		settle();
	endtask

	task automatic test_random_lists(input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] dep, input int idle, input int stall, input int n_items);
		int target;
		set_targets(w, h, dep);
		idle_pct = idle;
		stall_pct = stall;
		target = n_sent + n_items;
		while (n_sent < target) send_list($urandom_range(12, 1));
		settle();
	endtask

	// Receiver holds off for a long stretch while requests keep coming
	task automatic test_output_hold();
		set_targets(16'd640, 16'd480, 8'd16);
		idle_pct = 0;
		stall_pct = 0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 25; i++) send_list($urandom_range(3));
		settle();
	endtask

	// Sender stops mid-list until every result is out, then finishes the list
	task automatic test_drain_pause();
		set_targets(16'd800, 16'd600, 8'd24);
		idle_pct = 10;
		stall_pct = 30;
		for (int i = 0; i < 8; i++) begin
			for (int k = 0; k < 3; k++) send_request(random_mode());
			wait_drained();
			send_list($urandom_range(3));
		end
		settle();
	endtask

	// Receiver stall: random per cycle, or held high for a counted stretch
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		vmbms_pkg::vmbms_out_t want_res;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, got %p", $time, out_data);
				n_errors++;
			end else begin
				want_res = expected_results.pop_front();
				n_results++;
				if (want_res.exact) n_exact++;
				if (out_data.found !== want_res.found) begin
					$display("%0t: found mismatch: expected %0b, got %0b", $time,
						want_res.found, out_data.found);
					n_errors++;
				end
				if (out_data.best_mode !== want_res.best_mode) begin
					$display("%0t: best_mode mismatch: expected 0x%04h, got 0x%04h", $time,
						want_res.best_mode, out_data.best_mode);
					n_errors++;
				end
				if (out_data.exact !== want_res.exact) begin
					$display("%0t: exact mismatch: expected %0b, got %0b", $time,
						want_res.exact, out_data.exact);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: too long without any handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		n_errors = 0;
		n_sent = 0;
		n_lists = 0;
		n_results = 0;
		n_exact = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		want_w = vmbms_pkg::WANTED_WIDTH_RST;
		want_h = vmbms_pkg::WANTED_HEIGHT_RST;
		want_d = vmbms_pkg::WANTED_DEPTH_RST;
		clear_best();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_filters();
		test_unused_register();
		test_random_lists(vmbms_pkg::WANTED_WIDTH_RST, vmbms_pkg::WANTED_HEIGHT_RST,
			vmbms_pkg::WANTED_DEPTH_RST, 0, 0, 440);
		test_random_lists(16'd0, 16'd0, 8'd0, 59, 0, 440);
		test_random_lists(16'hFFFF, 16'hFFFF, 8'hFF, 0, 59, 440);
		test_random_lists(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
			8'($urandom_range(8'hFF)), 29, 29, 440);
		test_output_hold();
		test_drain_pause();
		settle();

		$display("Covered %0d mode requests in %0d lists, %0d results (%0d perfect matches),",
			n_sent, n_lists, n_results, n_exact);
		$display("across default, zero, full-scale and random targets with idle, stall and hold.");
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
